// ===== hdl/cpft_pkg.sv =====
`default_nettype none

package cpft_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC = DATA_WIDTH - 1;

  localparam int K_FRAC = 30;
  localparam int K_W = 32;
  localparam logic signed [K_W-1:0] K_INV_SQRT3 = 32'sd619925131;
  localparam logic signed [K_W-1:0] K_SQRT3 = 32'sd1859775393;

  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_CLARKE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ICLARKE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PARK = 3'd2;
  localparam logic [MODE_W-1:0] MODE_IPARK = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLARKE_PARK = 3'd4;
  localparam logic [MODE_W-1:0] MODE_IPARK_ICLARKE = 3'd5;

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int RP_W = DATA_WIDTH + 2;
  localparam int SUM_W = DATA_WIDTH + 2;
  localparam int CL_PROD_W = SUM_W + K_W;
  localparam int IC_MUL_W = DATA_WIDTH + K_W;
  localparam int IC_W = IC_MUL_W + 1;
  localparam int SAT_W = DATA_WIDTH + 5;

  localparam logic signed [SAT_W-1:0] SAT_HI =
    {{(SAT_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_LO =
    {{(SAT_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [PROD_W:0] HALF_P =
    {{(PROD_W+1-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic signed [CL_PROD_W:0] HALF_CL =
    {{(CL_PROD_W+1-K_FRAC){1'b0}}, 1'b1, {(K_FRAC-1){1'b0}}};
  localparam logic signed [IC_W:0] HALF_IC =
    {{(IC_W-K_FRAC){1'b0}}, 1'b1, {K_FRAC{1'b0}}};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic signed [DATA_WIDTH-1:0] in_first;
    logic signed [DATA_WIDTH-1:0] in_second;
    logic signed [DATA_WIDTH-1:0] sin_theta;
    logic signed [DATA_WIDTH-1:0] cos_theta;
  } cpft_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] out_first;
    logic signed [DATA_WIDTH-1:0] out_second;
    logic signed [DATA_WIDTH-1:0] out_third;
    logic saturated;
  } cpft_out_t;

  typedef struct packed {
    logic ovf;
    logic signed [DATA_WIDTH-1:0] val;
  } sat_t;

  function automatic sat_t sat_fn(input logic signed [SAT_W-1:0] v);
    sat_t r;
    r.ovf = 1'b1;
    if (v > SAT_HI) begin
      r.val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else if (v < SAT_LO) begin
      r.val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      r.ovf = 1'b0;
      r.val = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  // Q1.15 product rounded half up back to the data scale.
  function automatic logic signed [RP_W-1:0] rnd_prod(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    logic signed [PROD_W:0] sh;
    t = (PROD_W+1)'(p) + HALF_P;
    sh = t >>> FRAC;
    return sh[RP_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/clarke_park_frame_transform_unit.sv =====
// An accepted word passes the stage 1 to 4 registers and the output register
// to out_valid. Throughput: one word per cycle while out_stall is low; every
// stage moves on whenever the stage after it is empty or moving, so a stall on
// the output side only holds full stages. The critical paths are one multiplier
// per product stage and one rounding add and saturating compare per sum stage.
// Synchronous active-low reset clears all stage valid bits; data holds no reset.
`default_nettype none

module clarke_park_frame_transform_unit
  import cpft_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire cpft_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output cpft_out_t      out_data
);

  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;

  logic [MODE_W-1:0] s1_mode_r, s2_mode_r, s3_mode_r, s4_mode_r;

  logic signed [DATA_WIDTH-1:0] s1_x_r, s1_y_r, s1_s_r, s1_c_r;
  logic signed [CL_PROD_W-1:0] s1_cl_r, s1_cl_nxt;
  logic signed [SUM_W-1:0] cl_sum;
  logic signed [PROD_W-1:0] s1_xc_r, s1_ys_r, s1_yc_r, s1_xs_r;

  logic signed [DATA_WIDTH-1:0] s2_t0_r, s2_t1_r, s2_s_r, s2_c_r;
  logic signed [DATA_WIDTH-1:0] s2_t0_nxt, s2_t1_nxt;
  logic s2_flag_r, s2_flag_nxt;
  logic signed [CL_PROD_W:0] cl_t;
  logic signed [CL_PROD_W:0] cl_sh;
  sat_t sat_cl, sat_a, sat_b;

  logic signed [DATA_WIDTH-1:0] s3_t0_r, s3_t1_r;
  logic s3_flag_r;
  logic signed [PROD_W-1:0] s3_t0c_r, s3_t1s_r, s3_t1c_r, s3_t0s_r;
  logic signed [IC_MUL_W-1:0] s3_ic_r;

  logic signed [DATA_WIDTH-1:0] s4_r0_r, s4_r1_r, s4_r0_nxt, s4_r1_nxt;
  logic s4_flag_r, s4_flag_nxt;
  logic signed [IC_W-1:0] ic_wide;
  logic signed [IC_W:0] ic_t;
  logic signed [IC_W:0] ic_sh;
  sat_t sat_p0, sat_p1, sat_ic;

  sat_t sat_c;
  cpft_out_t out_data_r, out_nxt;

  assign rdy5 = !out_valid_r || !out_stall;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_stall = !rdy1;

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
      if (rdy5) out_valid_r <= s4_v_r;
    end
  end

  // Stage 1: operand products.
  always_comb begin
    cl_sum = SUM_W'(in_data.in_first) + SUM_W'(in_data.in_second)
           + SUM_W'(in_data.in_second);
    s1_cl_nxt = cl_sum * K_INV_SQRT3;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_mode_r <= in_data.mode;
      s1_x_r <= in_data.in_first;
      s1_y_r <= in_data.in_second;
      s1_s_r <= in_data.sin_theta;
      s1_c_r <= in_data.cos_theta;
      s1_cl_r <= s1_cl_nxt;
      s1_xc_r <= in_data.in_first * in_data.cos_theta;
      s1_ys_r <= in_data.in_second * in_data.sin_theta;
      s1_yc_r <= in_data.in_second * in_data.cos_theta;
      s1_xs_r <= in_data.in_first * in_data.sin_theta;
    end
  end

  // Stage 2: Clarke, Park, inverse Park or pass-through on the input operands.
  always_comb begin
    cl_t = (CL_PROD_W+1)'(s1_cl_r) + HALF_CL;
    cl_sh = cl_t >>> K_FRAC;
    sat_cl = sat_fn(cl_sh[SAT_W-1:0]);
    if (s1_mode_r == MODE_PARK) begin
      sat_a = sat_fn(SAT_W'(rnd_prod(s1_xc_r)) + SAT_W'(rnd_prod(s1_ys_r)));
      sat_b = sat_fn(SAT_W'(rnd_prod(s1_yc_r)) - SAT_W'(rnd_prod(s1_xs_r)));
    end else begin
      sat_a = sat_fn(SAT_W'(rnd_prod(s1_xc_r)) - SAT_W'(rnd_prod(s1_ys_r)));
      sat_b = sat_fn(SAT_W'(rnd_prod(s1_yc_r)) + SAT_W'(rnd_prod(s1_xs_r)));
    end
    case (s1_mode_r)
      MODE_CLARKE, MODE_CLARKE_PARK: begin
        s2_t0_nxt = s1_x_r;
        s2_t1_nxt = sat_cl.val;
        s2_flag_nxt = sat_cl.ovf;
      end
      MODE_ICLARKE: begin
        s2_t0_nxt = s1_x_r;
        s2_t1_nxt = s1_y_r;
        s2_flag_nxt = 1'b0;
      end
      MODE_PARK, MODE_IPARK, MODE_IPARK_ICLARKE: begin
        s2_t0_nxt = sat_a.val;
        s2_t1_nxt = sat_b.val;
        s2_flag_nxt = sat_a.ovf || sat_b.ovf;
      end
      default: begin
        s2_t0_nxt = '0;
        s2_t1_nxt = '0;
        s2_flag_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_mode_r <= s1_mode_r;
      s2_t0_r <= s2_t0_nxt;
      s2_t1_r <= s2_t1_nxt;
      s2_s_r <= s1_s_r;
      s2_c_r <= s1_c_r;
      s2_flag_r <= s2_flag_nxt;
    end
  end

  // Stage 3: products for a combined mode's second transform or inverse Clarke.
  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_mode_r <= s2_mode_r;
      s3_t0_r <= s2_t0_r;
      s3_t1_r <= s2_t1_r;
      s3_flag_r <= s2_flag_r;
      s3_t0c_r <= s2_t0_r * s2_c_r;
      s3_t1s_r <= s2_t1_r * s2_s_r;
      s3_t1c_r <= s2_t1_r * s2_c_r;
      s3_t0s_r <= s2_t0_r * s2_s_r;
      s3_ic_r <= s2_t1_r * K_SQRT3;
    end
  end

  // Stage 4: Park after Clarke, or the b phase of inverse Clarke.
  always_comb begin
    ic_wide = IC_W'(s3_ic_r) - (IC_W'(s3_t0_r) <<< K_FRAC);
    ic_t = (IC_W+1)'(ic_wide) + HALF_IC;
    ic_sh = ic_t >>> (K_FRAC + 1);
    sat_ic = sat_fn(ic_sh[SAT_W-1:0]);
    sat_p0 = sat_fn(SAT_W'(rnd_prod(s3_t0c_r)) + SAT_W'(rnd_prod(s3_t1s_r)));
    sat_p1 = sat_fn(SAT_W'(rnd_prod(s3_t1c_r)) - SAT_W'(rnd_prod(s3_t0s_r)));
    case (s3_mode_r)
      MODE_CLARKE_PARK: begin
        s4_r0_nxt = sat_p0.val;
        s4_r1_nxt = sat_p1.val;
        s4_flag_nxt = s3_flag_r || sat_p0.ovf || sat_p1.ovf;
      end
      MODE_ICLARKE, MODE_IPARK_ICLARKE: begin
        s4_r0_nxt = s3_t0_r;
        s4_r1_nxt = sat_ic.val;
        s4_flag_nxt = s3_flag_r || sat_ic.ovf;
      end
      default: begin
        s4_r0_nxt = s3_t0_r;
        s4_r1_nxt = s3_t1_r;
        s4_flag_nxt = s3_flag_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_mode_r <= s3_mode_r;
      s4_r0_r <= s4_r0_nxt;
      s4_r1_r <= s4_r1_nxt;
      s4_flag_r <= s4_flag_nxt;
    end
  end

  // Stage 5: phase c and the output register.
  always_comb begin
    sat_c = sat_fn(SAT_W'(0) - SAT_W'(s4_r0_r) - SAT_W'(s4_r1_r));
    out_nxt.out_first = s4_r0_r;
    out_nxt.out_second = s4_r1_r;
    if (s4_mode_r == MODE_ICLARKE || s4_mode_r == MODE_IPARK_ICLARKE) begin
      out_nxt.out_third = sat_c.val;
      out_nxt.saturated = s4_flag_r || sat_c.ovf;
    end else begin
      out_nxt.out_third = '0;
      out_nxt.saturated = s4_flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_data_r <= out_nxt;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && s3_v_r && s4_v_r && out_valid_r))
    else $error("input stalled while the pipeline has an empty stage");

  a_unused_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_mode_r > MODE_IPARK_ICLARKE)
      |-> (s2_t0_r == '0 && s2_t1_r == '0 && !s2_flag_r))
    else $error("unused mode left nonzero data in stage 2");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall |=> out_valid)
    else $error("accepted word did not reach the output in five cycles");

  a_phase_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.saturated)
      |-> (out_data.out_third == '0 ||
           DATA_WIDTH'(out_data.out_first + out_data.out_second
                       + out_data.out_third) == '0))
    else $error("unsaturated phases do not sum to zero");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  import cpft_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  localparam logic signed [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  localparam int IDLE_PCT = 31;
  localparam int RANDOM_WORDS = 700;
  localparam int SEND_CALM_LO = 350;
  localparam int SEND_CALM_HI = 550;
  localparam int RECV_HOLD_LO = 150;
  localparam int RECV_HOLD_LEN = 120;
  localparam int RECV_CALM_LO = 600;
  localparam int RECV_CALM_HI = 900;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cpft_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cpft_out_t out_data;

  cpft_in_t sample_queue[$];
  cpft_out_t transform_queue[$];
  int mismatches = 0;
  int words_sent = 0;
  int recv_cycles = 0;
  int quiet_cycles = 0;

  clarke_park_frame_transform_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Round half up: add half an LSB of the dropped bits, then floor.
  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip_q15(input longint v, inout bit clipped);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clipped = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clipped = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint q15_mul(input longint x, input longint y);
    return round_half_up(x * y, FRAC);
  endfunction

  function automatic void to_alpha_beta(input longint a, input longint b,
                                        output longint al, output longint be,
                                        inout bit clipped);
    al = clip_q15(a, clipped);
    be = clip_q15(round_half_up((a + 2 * b) * longint'(K_INV_SQRT3), K_FRAC), clipped);
  endfunction

  function automatic void to_three_phase(input longint al, input longint be,
                                         output longint a, output longint b,
                                         output longint c, inout bit clipped);
    longint wide;
    wide = be * longint'(K_SQRT3) - al * (longint'(1) <<< K_FRAC);
    a = clip_q15(al, clipped);
    b = clip_q15(round_half_up(wide, K_FRAC + 1), clipped);
    c = clip_q15(-a - b, clipped);
  endfunction

  function automatic void rotate_to_dq(input longint al, input longint be,
                                       input longint s, input longint c,
                                       output longint d, output longint q,
                                       inout bit clipped);
    d = clip_q15(q15_mul(al, c) + q15_mul(be, s), clipped);
    q = clip_q15(q15_mul(be, c) - q15_mul(al, s), clipped);
  endfunction

  function automatic void rotate_to_ab(input longint d, input longint q,
                                       input longint s, input longint c,
                                       output longint al, output longint be,
                                       inout bit clipped);
    al = clip_q15(q15_mul(d, c) - q15_mul(q, s), clipped);
    be = clip_q15(q15_mul(q, c) + q15_mul(d, s), clipped);
  endfunction

  function automatic cpft_out_t compute_transform(input cpft_in_t w);
    longint x;
    longint y;
    longint s;
    longint c;
    longint r0;
    longint r1;
    longint r2;
    longint t0;
    longint t1;
    bit clipped;
    cpft_out_t res;
    x = w.in_first;
    y = w.in_second;
    s = w.sin_theta;
    c = w.cos_theta;
    r0 = 0;
    r1 = 0;
    r2 = 0;
    clipped = 1'b0;
    case (w.mode)
      MODE_CLARKE: begin
        to_alpha_beta(x, y, r0, r1, clipped);
      end
      MODE_ICLARKE: begin
        to_three_phase(x, y, r0, r1, r2, clipped);
      end
      MODE_PARK: begin
        rotate_to_dq(x, y, s, c, r0, r1, clipped);
      end
      MODE_IPARK: begin
        rotate_to_ab(x, y, s, c, r0, r1, clipped);
      end
      MODE_CLARKE_PARK: begin
        to_alpha_beta(x, y, t0, t1, clipped);
        rotate_to_dq(t0, t1, s, c, r0, r1, clipped);
      end
      MODE_IPARK_ICLARKE: begin
        rotate_to_ab(x, y, s, c, t0, t1, clipped);
        to_three_phase(t0, t1, r0, r1, r2, clipped);
      end
      default: begin
      end
    endcase
    res.out_first = r0[DATA_WIDTH-1:0];
    res.out_second = r1[DATA_WIDTH-1:0];
    res.out_third = r2[DATA_WIDTH-1:0];
    res.saturated = clipped;
    return res;
  endfunction

  function automatic cpft_in_t make_word(input logic [MODE_W-1:0] mode,
                                         input int a,
                                         input int b,
                                         input int s,
                                         input int c);
    cpft_in_t w;
    w.mode = mode;
    w.in_first = DATA_WIDTH'(a);
    w.in_second = DATA_WIDTH'(b);
    w.sin_theta = DATA_WIDTH'(s);
    w.cos_theta = DATA_WIDTH'(c);
    return w;
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] pick_operand();
    logic signed [DATA_WIDTH-1:0] v;
    v = DATA_WIDTH'($urandom);
    case ($urandom_range(0, 9))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2: v = DATA_WIDTH'($urandom_range(0, 2) - 1);
      3, 4: v = $signed(v) >>> 3;
      default: begin
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic signed [DATA_WIDTH-1:0] got,
                                 input logic signed [DATA_WIDTH-1:0] want);
    if (mismatches < 40) begin
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        transform_queue.push_back(compute_transform(in_data));
        words_sent++;
      end
      if (sample_queue.size() != 0 &&
          ((words_sent >= SEND_CALM_LO && words_sent < SEND_CALM_HI) ||
           $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_data <= sample_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_cycles <= 0;
    end else begin
      recv_cycles <= recv_cycles + 1;
      if (recv_cycles >= RECV_HOLD_LO && recv_cycles < RECV_HOLD_LO + RECV_HOLD_LEN) begin
        out_stall <= 1'b1;
      end else if (recv_cycles >= RECV_CALM_LO && recv_cycles < RECV_CALM_HI) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : monitor
    cpft_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (transform_queue.size() == 0) begin
        report_mismatch("word with nothing expected", out_data.out_first, '0);
      end else begin
        want = transform_queue.pop_front();
        if (out_data.out_first !== want.out_first) begin
          report_mismatch("out_first", out_data.out_first, want.out_first);
        end
        if (out_data.out_second !== want.out_second) begin
          report_mismatch("out_second", out_data.out_second, want.out_second);
        end
        if (out_data.out_third !== want.out_third) begin
          report_mismatch("out_third", out_data.out_third, want.out_third);
        end
        if (out_data.saturated !== want.saturated) begin
          report_mismatch("saturated", out_data.saturated, want.saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [MODE_W-1:0] mode;
    logic signed [DATA_WIDTH-1:0] s;
    logic signed [DATA_WIDTH-1:0] c;
    real ang;
    sample_queue.push_back(make_word(MODE_CLARKE, 0, 0, 0, 0));
    sample_queue.push_back(make_word(MODE_CLARKE, Q_MAX, Q_MAX, 0, Q_MAX));
    sample_queue.push_back(make_word(MODE_CLARKE, Q_MIN, Q_MIN, Q_MIN, 0));
    sample_queue.push_back(make_word(MODE_CLARKE, 1, -1, 1, -1));
    sample_queue.push_back(make_word(MODE_ICLARKE, Q_MIN, Q_MAX, 0, 0));
    sample_queue.push_back(make_word(MODE_ICLARKE, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    sample_queue.push_back(make_word(MODE_ICLARKE, Q_MAX, Q_MAX, 0, 0));
    sample_queue.push_back(make_word(MODE_ICLARKE, -1, 1, 0, 0));
    sample_queue.push_back(make_word(MODE_PARK, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    sample_queue.push_back(make_word(MODE_PARK, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    sample_queue.push_back(make_word(MODE_PARK, 1000, -2000, 0, Q_MAX));
    sample_queue.push_back(make_word(MODE_IPARK, Q_MIN, Q_MAX, Q_MAX, Q_MIN));
    sample_queue.push_back(make_word(MODE_IPARK, Q_MAX, Q_MAX, Q_MIN, Q_MAX));
    sample_queue.push_back(make_word(MODE_IPARK, 12345, -6789, 23170, 23170));
    sample_queue.push_back(make_word(MODE_CLARKE_PARK, Q_MAX, Q_MAX, 0, Q_MAX));
    sample_queue.push_back(make_word(MODE_CLARKE_PARK, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    sample_queue.push_back(make_word(MODE_CLARKE_PARK, 5000, 3000, 16384, 28378));
    sample_queue.push_back(make_word(MODE_IPARK_ICLARKE, Q_MAX, Q_MAX, Q_MIN, Q_MIN));
    sample_queue.push_back(make_word(MODE_IPARK_ICLARKE, Q_MIN, Q_MAX, Q_MAX, Q_MIN));
    sample_queue.push_back(make_word(MODE_IPARK_ICLARKE, 8000, -4000, -16384, 28378));
    sample_queue.push_back(make_word(MODE_SPARE_A, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    sample_queue.push_back(make_word(MODE_SPARE_B, $urandom, $urandom, $urandom, $urandom));

    // Half of the rotations use a consistent sine and cosine pair, the rest
    // take arbitrary values so that the products reach saturation.
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if ($urandom_range(0, 99) < 3) begin
        mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
      end else begin
        mode = MODE_W'($urandom_range(0, 5));
      end
      if ($urandom_range(0, 1) == 0) begin
        ang = $urandom_range(0, 62831) / 10000.0;
        s = DATA_WIDTH'($rtoi($sin(ang) * 32767.0));
        c = DATA_WIDTH'($rtoi($cos(ang) * 32767.0));
      end else begin
        s = pick_operand();
        c = pick_operand();
      end
      sample_queue.push_back(make_word(mode, pick_operand(), pick_operand(), s, c));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (sample_queue.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (transform_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/cpft_pkg.sv
hdl/clarke_park_frame_transform_unit.sv
tb/tb_top.sv
